// File: rtl/tbs_pkg.sv
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types, register map, defaults and the quarter-wave sine generator
// for the tone burst sequencer.
// ----------------------------------------------------------------------------
package tbs_pkg;

   localparam int DEF_MAX_NOTES       = 4;
   localparam int DEF_SINE_TABLE_BITS = 10;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_NOTE_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_STEP_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_STEP_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_STEP_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_STEP_3 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_STEP = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_GAP_LENGTH   = 3'd6;

   localparam logic [2:0]  RST_NOTE_COUNT   = 3'd4;
   localparam logic [15:0] RST_RELEASE_STEP = 16'd46;
   localparam logic [15:0] RST_GAP_LENGTH   = 16'd1440;

   localparam logic [15:0] ENV_FULL = 16'h8000;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic [2:0]       note_count;
      logic [3:0][31:0] phase_step;
      logic [15:0]      release_step;
      logic [15:0]      gap_length;
   } cfg_type;

   // work handed from the sequencer to the mixing stage
   typedef struct packed {
      logic signed [15:0] sample;
      logic signed [15:0] sine;
      logic [15:0]        env;
      logic               tone_en;
      logic               busy;
   } stage_type;

   // round(32767*sin(a*pi/(2*quarter))) from a Q30 Taylor series, quarter = 2^(bits-2)
   function automatic logic [14:0] quarter_sine(input int unsigned a, input int table_bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          r;
      x    = (HALF_PI_Q30 * longint'(a)) >> (table_bits - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      r = longint'((longint'(sum) * 32767 + (longint'(1) << 29)) >>> 30);
      if (r > 32767) begin
         r = 32767;
      end
      return r[14:0];
   endfunction

endpackage

// File: rtl/sine_tone_burst_sequencer.sv
// Path: an accepted request beat is registered in stage 1, then in the output register.
// Throughput: one beat per cycle unless rsp_stall holds a full pipe; the state loop
//   (envelope subtract, note advance, phase add) is combinational, once per beat.
// Reset: synchronous; clears sequencer state and both pipeline stages and
//   loads the configuration registers with their defaults. No clearing pass.
// ----------------------------------------------------------------------------
// sine_tone_burst_sequencer
// Adds a decaying multi-note sine burst to a stream of audio samples.
// ----------------------------------------------------------------------------
module sine_tone_burst_sequencer #(
   parameter int MAX_NOTES       = tbs_pkg::DEF_MAX_NOTES,
   parameter int SINE_TABLE_BITS = tbs_pkg::DEF_SINE_TABLE_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_start_req,
   input  logic signed [15:0]             req_in_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [15:0]             rsp_out_sample,
   output logic                           rsp_busy_res,
   input  logic                           csr_we,
   input  logic [tbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tbs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tbs_pkg::*;

   cfg_type   cfg;
   stage_type stage_new;
   stage_type s1_ff;
   logic      s1_valid_ff, s1_valid_in;
   logic      out_valid_ff, out_valid_in;
   logic signed [15:0] out_sample_ff, out_sample_in;
   logic      out_busy_ff;
   logic      adv_out;
   logic      req_accept;

   logic signed [32:0] prod;
   logic signed [33:0] prod_rnd;
   logic signed [15:0] tone;
   logic signed [16:0] sum;

   tbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tbs_seq #(
      .MAX_NOTES  (MAX_NOTES),
      .TABLE_BITS (SINE_TABLE_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (req_accept),
      .start_req (req_start_req),
      .in_sample (req_in_sample),
      .stage     (stage_new)
   );

   // advance the pipe whenever the output register is free or being drained
   assign adv_out    = !out_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !adv_out;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !adv_out);
   assign out_valid_in = adv_out ? s1_valid_ff : out_valid_ff;

   // tone = round(sine * env / 2^16), then saturating mix
   always_comb begin
      prod     = s1_ff.sine * $signed({1'b0, s1_ff.env});
      prod_rnd = 34'(prod) + 34'sd32768;
      tone     = s1_ff.tone_en ? prod_rnd[31:16] : 16'sd0;
      sum      = 17'(s1_ff.sample) + 17'(tone);
      if (sum > 17'sd32767) begin
         out_sample_in = 16'sh7fff;
      end else if (sum < -17'sd32768) begin
         out_sample_in = 16'sh8000;
      end else begin
         out_sample_in = sum[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= stage_new;
      end
      if (adv_out && s1_valid_ff) begin
         out_sample_ff <= out_sample_in;
         out_busy_ff   <= s1_ff.busy;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_sample = out_sample_ff;
   assign rsp_busy_res   = out_busy_ff;

   // a stalled request means both stages are full and the output is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled without a full pipe");

   // a note beat never ends the sequence
   a_tone_busy: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.tone_en) |-> s1_ff.busy)
      else $error("tone beat marked idle");

   // a start request always produces a busy note beat
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_start_req) |=> (s1_valid_ff && s1_ff.busy && s1_ff.tone_en))
      else $error("start request did not begin a note");

   // stage 1 drains into the output register with no beat lost
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && adv_out && !req_accept) |=> (out_valid_ff && !s1_valid_ff))
      else $error("stage 1 beat lost");

endmodule

// File: rtl/tbs_csr.sv
// ----------------------------------------------------------------------------
// tbs_csr
// Configuration register file, write-only.
// ----------------------------------------------------------------------------
module tbs_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [tbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tbs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output tbs_pkg::cfg_type               cfg
);
   import tbs_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_NOTE_COUNT:   cfg_in.note_count    = csr_wdata[2:0];
            REG_PHASE_STEP_0: cfg_in.phase_step[0] = csr_wdata;
            REG_PHASE_STEP_1: cfg_in.phase_step[1] = csr_wdata;
            REG_PHASE_STEP_2: cfg_in.phase_step[2] = csr_wdata;
            REG_PHASE_STEP_3: cfg_in.phase_step[3] = csr_wdata;
            REG_RELEASE_STEP: cfg_in.release_step  = csr_wdata[15:0];
            REG_GAP_LENGTH:   cfg_in.gap_length    = csr_wdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.note_count   <= RST_NOTE_COUNT;
         cfg_ff.phase_step   <= '0;
         cfg_ff.release_step <= RST_RELEASE_STEP;
         cfg_ff.gap_length   <= RST_GAP_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/tbs_sine.sv
// ----------------------------------------------------------------------------
// tbs_sine
// Sine lookup from a quarter-wave constant table, mirrored by quadrant.
// ----------------------------------------------------------------------------
module tbs_sine #(
   parameter int TABLE_BITS = tbs_pkg::DEF_SINE_TABLE_BITS
) (
   input  logic [TABLE_BITS-1:0] phase,
   output logic signed [15:0]    sine
);
   import tbs_pkg::*;

   localparam int QUARTER = 1 << (TABLE_BITS - 2);
   localparam logic [TABLE_BITS-2:0] QTR_ADDR = (TABLE_BITS-1)'(QUARTER);

   logic [14:0]           qtr [QUARTER+1];
   logic [1:0]            quad;
   logic [TABLE_BITS-2:0] addr;
   logic [14:0]           mag;

   for (genvar k = 0; k <= QUARTER; k++) begin : g_qtr
      assign qtr[k] = quarter_sine(k, TABLE_BITS);
   end

   always_comb begin
      quad = phase[TABLE_BITS-1:TABLE_BITS-2];
      // second and fourth quadrants run the quarter wave backwards
      if (quad[0]) begin
         addr = QTR_ADDR - {1'b0, phase[TABLE_BITS-3:0]};
      end else begin
         addr = {1'b0, phase[TABLE_BITS-3:0]};
      end
      mag = qtr[addr];
      if (quad[1]) begin
         sine = -$signed({1'b0, mag});
      end else begin
         sine = $signed({1'b0, mag});
      end
   end

endmodule

// File: rtl/tbs_seq.sv
// ----------------------------------------------------------------------------
// tbs_seq
// Note and gap sequencer: phase accumulator, envelope and gap counter,
// updated once per accepted beat.
// ----------------------------------------------------------------------------
module tbs_seq #(
   parameter int MAX_NOTES  = tbs_pkg::DEF_MAX_NOTES,
   parameter int TABLE_BITS = tbs_pkg::DEF_SINE_TABLE_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  tbs_pkg::cfg_type   cfg,
   input  logic               accept,
   input  logic               start_req,
   input  logic signed [15:0] in_sample,
   output tbs_pkg::stage_type stage
);
   import tbs_pkg::*;

   localparam logic [2:0] MAX_CNT = 3'(MAX_NOTES);

   logic        running_ff, running_in;
   logic        gap_phase_ff, gap_phase_in;
   logic [1:0]  current_note_ff, current_note_in;
   logic [31:0] phase_acc_ff, phase_acc_in;
   logic [15:0] env_level_ff, env_level_in;
   logic [15:0] gap_left_ff, gap_left_in;

   logic [31:0] phase_cur;
   logic [2:0]  eff_count;
   logic [1:0]  note_next;
   logic signed [15:0] sine;

   always_comb begin
      if (cfg.note_count == 3'd0) begin
         eff_count = 3'd1;
      end else if (cfg.note_count > MAX_CNT) begin
         eff_count = MAX_CNT;
      end else begin
         eff_count = cfg.note_count;
      end
   end

   assign phase_cur = start_req ? 32'd0 : phase_acc_ff;

   tbs_sine #(.TABLE_BITS(TABLE_BITS)) u_sine (
      .phase (phase_cur[31 -: TABLE_BITS]),
      .sine  (sine)
   );

   always_comb begin
      running_in      = running_ff;
      gap_phase_in    = gap_phase_ff;
      current_note_in = current_note_ff;
      phase_acc_in    = phase_acc_ff;
      env_level_in    = env_level_ff;
      gap_left_in     = gap_left_ff;
      note_next       = current_note_ff + 2'd1;
      if (start_req) begin
         running_in      = 1'b1;
         gap_phase_in    = 1'b0;
         current_note_in = 2'd0;
         phase_acc_in    = 32'd0;
         env_level_in    = ENV_FULL;
         gap_left_in     = 16'd0;
         note_next       = 2'd1;
      end
      stage.sample  = in_sample;
      stage.sine    = sine;
      stage.tone_en = 1'b0;
      if (running_in) begin
         if (gap_phase_in) begin
            if (gap_left_in <= 16'd1) begin
               gap_left_in     = 16'd0;
               current_note_in = note_next;
               if (note_next == 2'd0 || {1'b0, note_next} >= eff_count) begin
                  running_in = 1'b0;
               end else begin
                  phase_acc_in = 32'd0;
                  env_level_in = ENV_FULL;
                  gap_phase_in = 1'b0;
               end
            end else begin
               gap_left_in = gap_left_in - 16'd1;
            end
         end else begin
            if (env_level_in > cfg.release_step) begin
               env_level_in = env_level_in - cfg.release_step;
            end else begin
               env_level_in = 16'd0;
            end
            if (env_level_in == 16'd0) begin
               gap_phase_in = 1'b1;
               gap_left_in  = cfg.gap_length;
            end
            stage.tone_en = 1'b1;
            phase_acc_in  = phase_acc_in + cfg.phase_step[current_note_in];
         end
      end
      stage.env  = env_level_in;
      stage.busy = running_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff      <= 1'b0;
         gap_phase_ff    <= 1'b0;
         current_note_ff <= 2'd0;
         phase_acc_ff    <= 32'd0;
         env_level_ff    <= 16'd0;
         gap_left_ff     <= 16'd0;
      end else if (accept) begin
         running_ff      <= running_in;
         gap_phase_ff    <= gap_phase_in;
         current_note_ff <= current_note_in;
         phase_acc_ff    <= phase_acc_in;
         env_level_ff    <= env_level_in;
         gap_left_ff     <= gap_left_in;
      end
   end

endmodule

// File: dv/sine_tone_burst_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_tone_burst_sequencer_tb
// Drives audio sample beats with start requests into the tone burst sequencer
// and checks every response beat against a cycle-free model of the note,
// envelope, gap and phase sequencing, the sine table and the saturating mix.
// ----------------------------------------------------------------------------
module sine_tone_burst_sequencer_tb;
   import tbs_pkg::*;

   localparam int SINE_BITS    = DEF_SINE_TABLE_BITS;
   localparam int TBL_SIZE     = 1 << SINE_BITS;
   localparam int QUARTER_SIZE = TBL_SIZE / 4;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;

   typedef struct {
      logic signed [15:0] out_sample;
      logic               busy_res;
   } mix_beat_type;

   // Tracks the sequencer state and holds the mixed samples still due.
   class tone_mix_scoreboard;
      int           sine_rom [TBL_SIZE];
      logic [2:0]   note_count;
      logic [31:0]  phase_step [4];
      logic [15:0]  release_step;
      logic [15:0]  gap_length;
      bit           active;
      bit           in_gap;
      logic [1:0]   note;
      logic [31:0]  phase;
      logic [15:0]  env;
      logic [15:0]  gap_left;
      mix_beat_type mix_due [$];
      int           errors;

      function new();
         int v;
         int unsigned quad;
         int unsigned r;
         for (int k = 0; k < TBL_SIZE; k++) begin
            quad = k / QUARTER_SIZE;
            r    = k % QUARTER_SIZE;
            v    = quad[0] ? quarter_wave(QUARTER_SIZE - r) : quarter_wave(r);
            sine_rom[k] = quad[1] ? -v : v;
         end
         note_count   = RST_NOTE_COUNT;
         for (int i = 0; i < 4; i++) phase_step[i] = '0;
         release_step = RST_RELEASE_STEP;
         gap_length   = RST_GAP_LENGTH;
         active       = 0;
         in_gap       = 0;
         note         = '0;
         phase        = '0;
         env          = '0;
         gap_left     = '0;
         errors       = 0;
      endfunction

      // Q30 Taylor series for one quarter wave, scaled to 32767 and rounded
      function int quarter_wave(int unsigned a);
         longint unsigned x;
         longint unsigned x2;
         longint unsigned term;
         longint          sum;
         longint          r;
         x    = (HALF_PI_Q30 * 64'(a)) / 64'(QUARTER_SIZE);
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / 64'(2 * n * (2 * n + 1));
            if (n % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         r = longint'(($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30);
         if (r > 32767) r = 32767;
         return int'(r);
      endfunction

      function void configure(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
         case (idx)
            REG_NOTE_COUNT:   note_count    = val[2:0];
            REG_PHASE_STEP_0: phase_step[0] = val;
            REG_PHASE_STEP_1: phase_step[1] = val;
            REG_PHASE_STEP_2: phase_step[2] = val;
            REG_PHASE_STEP_3: phase_step[3] = val;
            REG_RELEASE_STEP: release_step  = val[15:0];
            REG_GAP_LENGTH:   gap_length    = val[15:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return mix_due.size();
      endfunction

      // Advance the sequencer by one accepted sample beat and queue its mix.
      function void take_sample(logic start, logic signed [15:0] in_sample);
         int           tone;
         int           sum;
         int           limit;
         longint       prod;
         mix_beat_type beat;
         tone = 0;
         if (note_count == 0) limit = 1;
         else if (note_count > DEF_MAX_NOTES) limit = DEF_MAX_NOTES;
         else limit = note_count;
         if (start) begin
            active   = 1;
            in_gap   = 0;
            note     = '0;
            phase    = '0;
            env      = ENV_FULL;
            gap_left = '0;
         end
         if (active) begin
            if (in_gap) begin
               if (gap_left <= 16'd1) begin
                  gap_left = '0;
                  note     = note + 2'd1;
                  if (note == 2'd0 || int'(note) >= limit) begin
                     active = 0;
                  end else begin
                     phase  = '0;
                     env    = ENV_FULL;
                     in_gap = 0;
                  end
               end else begin
                  gap_left = gap_left - 16'd1;
               end
            end else begin
               env = (env > release_step) ? env - release_step : 16'd0;
               if (env == 16'd0) begin
                  in_gap   = 1;
                  gap_left = gap_length;
               end
               // tone uses the envelope after this sample's decrement; round half up
               prod  = longint'(sine_rom[phase >> (32 - SINE_BITS)]) * longint'(env);
               tone  = int'((prod + 64'sd32768) >>> 16);
               phase = phase + phase_step[note];
            end
         end
         sum = int'(in_sample) + tone;
         if (sum > 32767) sum = 32767;
         if (sum < -32768) sum = -32768;
         beat.out_sample = sum[15:0];
         beat.busy_res   = active;
         mix_due.push_back(beat);
      endfunction

      function void check_mix(logic signed [15:0] out_sample, logic busy_res);
         mix_beat_type want;
         if (mix_due.size() == 0) begin
            $error("response beat with no sample outstanding: out_sample=%0d busy_res=%0b",
                   out_sample, busy_res);
            errors++;
            return;
         end
         want = mix_due.pop_front();
         if (out_sample !== want.out_sample) begin
            $error("out_sample: expected %0d, got %0d", want.out_sample, out_sample);
            errors++;
         end
         if (busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, busy_res);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic                  req_start_req = 1'b0;
   logic signed [15:0]    req_in_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic signed [15:0]    rsp_out_sample;
   logic                  rsp_busy_res;
   logic                  csr_we        = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index     = '0;
   logic [CSR_DATA_W-1:0] csr_wdata     = '0;

   tone_mix_scoreboard mix_sb;
   logic [31:0]        reg_val [8];
   bit                 idle_on = 0;
   int                 hold_left = 0;
   int                 sent = 0;

   sine_tone_burst_sequencer uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_start_req  (req_start_req),
      .req_in_sample  (req_in_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_sample (rsp_out_sample),
      .rsp_busy_res   (rsp_busy_res),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Sample both handshakes on pre-edge values.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) mix_sb.take_sample(req_start_req, req_in_sample);
         if (rsp_valid && !rsp_stall) mix_sb.check_mix(rsp_out_sample, rsp_busy_res);
      end
   end

   // Receiver back-pressure in random bursts.
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         hold_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_beat(input logic start, input logic signed [15:0] smp);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_start_req <= start;
      req_in_sample <= smp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   // Drop valid and hold until every outstanding mix has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      // let the monitor note the last accepted beat first
      @(posedge clock);
      while (mix_sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_regs(input bit [7:0] mask);
      for (int i = 0; i < 8; i++) begin
         if (mask[i]) begin
            csr_we    <= 1'b1;
            csr_index <= 3'(i);
            csr_wdata <= reg_val[i];
            @(posedge clock);
            mix_sb.configure(3'(i), reg_val[i]);
         end
      end
      csr_we <= 1'b0;
   endtask

   task automatic pick_setting();
      reg_val[REG_NOTE_COUNT] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                             : $urandom_range(1, 4);
      for (int i = 0; i < 4; i++) begin
         case ($urandom_range(0, 5))
            0:       reg_val[REG_PHASE_STEP_0 + i] = 32'h0000_0000;
            1:       reg_val[REG_PHASE_STEP_0 + i] = 32'hFFFF_FFFF;
            default: reg_val[REG_PHASE_STEP_0 + i] = $urandom;
         endcase
      end
      case ($urandom_range(0, 9))
         0:       reg_val[REG_RELEASE_STEP] = 65535;
         1:       reg_val[REG_RELEASE_STEP] = 32768;
         2:       reg_val[REG_RELEASE_STEP] = 1;
         3:       reg_val[REG_RELEASE_STEP] = 0;
         default: reg_val[REG_RELEASE_STEP] = $urandom_range(1500, 32768);
      endcase
      case ($urandom_range(0, 7))
         0:       reg_val[REG_GAP_LENGTH] = 0;
         1:       reg_val[REG_GAP_LENGTH] = 65535;
         default: reg_val[REG_GAP_LENGTH] = $urandom_range(1, 12);
      endcase
      reg_val[REG_UNMAPPED] = $urandom;
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int                 n;
      logic               start;
      logic signed [15:0] smp;
      mix_sb = new();
      repeat (11) @(posedge clock);
      reset   <= 1'b0;
      idle_on = 1;

      // idle: samples pass straight through
      send_beat(1'b0, 16'sh7FFF);
      send_beat(1'b0, 16'sh8000);
      send_beat(1'b0, 16'sh0000);
      wait_drained();

      // note count above the maximum, zero gap, short notes driving saturation
      reg_val[REG_NOTE_COUNT]   = 7;
      reg_val[REG_PHASE_STEP_0] = 32'h4000_0000;
      reg_val[REG_PHASE_STEP_1] = 32'hFFFF_FFFF;
      reg_val[REG_PHASE_STEP_2] = 32'hC000_0000;
      reg_val[REG_PHASE_STEP_3] = 32'h8000_0000;
      reg_val[REG_RELEASE_STEP] = 10923;
      reg_val[REG_GAP_LENGTH]   = 0;
      reg_val[REG_UNMAPPED]     = $urandom;
      load_regs(8'hFF);
      for (int k = 0; k < 16; k++) begin
         case (k / 4)
            0:       smp = 16'sh7FFF;
            1:       smp = pick_sample();
            2:       smp = 16'sh8000;
            default: smp = 16'sh0000;
         endcase
         send_beat(k == 0, smp);
      end
      wait_drained();

      // zero release step holds the note; zero note count clamps to one
      reg_val[REG_NOTE_COUNT]   = 0;
      reg_val[REG_RELEASE_STEP] = 0;
      load_regs(8'h21);
      send_beat(1'b1, 16'sh7FFF);
      send_beat(1'b0, 16'sh7FFF);
      send_beat(1'b0, 16'sh7FFF);
      wait_drained();

      // release step above full scale ends the note on its first sample
      reg_val[REG_RELEASE_STEP] = 65535;
      load_regs(8'h20);
      send_beat(1'b1, 16'sh8000);
      send_beat(1'b0, 16'sh8000);

      while (sent < 620) begin
         wait_drained();
         pick_setting();
         load_regs(8'($urandom_range(1, 255)));
         idle_on = ($urandom_range(0, 3) != 0);
         n = $urandom_range(30, 90);
         for (int k = 0; k < n; k++) begin
            // mostly a clean start, occasionally a restart mid-sequence
            if (k == 0) start = ($urandom_range(0, 3) != 0);
            else start = ($urandom_range(0, 39) == 0);
            send_beat(start, pick_sample());
         end
      end

      // closing stretch at full rate on both sides
      wait_drained();
      idle_on = 0;
      reg_val[REG_NOTE_COUNT]   = 4;
      reg_val[REG_PHASE_STEP_0] = $urandom;
      reg_val[REG_PHASE_STEP_1] = $urandom;
      reg_val[REG_PHASE_STEP_2] = $urandom;
      reg_val[REG_PHASE_STEP_3] = $urandom;
      reg_val[REG_RELEASE_STEP] = 6000;
      reg_val[REG_GAP_LENGTH]   = 2;
      load_regs(8'h7F);
      for (int k = 0; k < 100; k++) begin
         send_beat(k == 0 || $urandom_range(0, 49) == 0, pick_sample());
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (mix_sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
